// ----- design/eslr_pkg.sv -----
// Package: shared types, constants and codes of the expert slot reserver.
package eslr_pkg;

  // Parameter defaults
  localparam int DEF_NUM_EXPERTS = 64;
  localparam int DEF_SLOTS       = 16;
  localparam int DEF_MAX_BATCH   = 16;
  localparam int DEF_NUM_TABLES  = 8;

  // Fixed limits and field widths
  localparam int MAX_RESULTS = 16;
  localparam int ROW_W       = 12;
  localparam int EXP_W       = 6;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int OP_W        = 5;

  // Input actions
  localparam logic [1:0] ACT_PREDICT = 2'd0;
  localparam logic [1:0] ACT_PUBLISH = 2'd1;
  localparam logic [1:0] ACT_RETURN  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LFU_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESIDENT_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_SLOTS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW      = 2'd3;

  // Datapath operation codes
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd1;
  localparam logic [OP_W-1:0] OP_ACCEPT   = 5'd2;
  localparam logic [OP_W-1:0] OP_RET      = 5'd3;
  localparam logic [OP_W-1:0] OP_PUB_RD   = 5'd4;
  localparam logic [OP_W-1:0] OP_PUB_WR   = 5'd5;
  localparam logic [OP_W-1:0] OP_INIT     = 5'd6;
  localparam logic [OP_W-1:0] OP_LEG_RD   = 5'd7;
  localparam logic [OP_W-1:0] OP_LEG_EV   = 5'd8;
  localparam logic [OP_W-1:0] OP_BUMP_RD  = 5'd9;
  localparam logic [OP_W-1:0] OP_BUMP_EV  = 5'd10;
  localparam logic [OP_W-1:0] OP_MISS_RD  = 5'd11;
  localparam logic [OP_W-1:0] OP_MISS_EV  = 5'd12;
  localparam logic [OP_W-1:0] OP_POP      = 5'd13;
  localparam logic [OP_W-1:0] OP_VIC_RD   = 5'd14;
  localparam logic [OP_W-1:0] OP_VIC_EV   = 5'd15;
  localparam logic [OP_W-1:0] OP_VIC_END  = 5'd16;
  localparam logic [OP_W-1:0] OP_FLUSH    = 5'd17;

  typedef struct packed {
    logic [1:0]       action;
    logic [2:0]       table_index;
    logic [EXP_W-1:0] expert_id;
    logic [ROW_W-1:0] row;
    logic             batch_last;
  } in_item_t;

  typedef struct packed {
    logic [EXP_W-1:0] reserved_expert;
    logic [ROW_W-1:0] reserved_row;
    logic             nothing_to_read;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic init_done;
    logic lfu;
    logic scan_last;
    logic bump_done;
    logic miss_done;
    logic hit;
    logic depth_nz;
  } stat_t;

endpackage

// ----- design/expert_slot_lfu_reserver_core.sv -----
// Top level: expert slot reserver with LFU or legacy replacement.
//
//   channel  ports                              direction  handshake
//   input    start, busy, in_data               in         start & !busy
//   result   out_valid, out_data                out        out_valid, one cycle
//   config   cfg_valid, cfg_ready, cfg_index,   in         cfg_valid & cfg_ready
//            cfg_data
//
// After reset a clearing pass writes all NUM_TABLES*NUM_EXPERTS words (512 by default)
// and so empties the map/count memory; busy stays high meanwhile.
// A publish is a read-modify-write of the map entry.
// Reservation: first use pushes up to SLOTS rows, one a cycle; legacy mode scans
// all NUM_EXPERTS entries; LFU bumps the count of each id; each miss pops a free
// row if one is left, else in LFU mode scans the map for a victim over the single
// map memory read port. Results come out one per cycle at most; they cannot stall.
module expert_slot_lfu_reserver_core #(
  parameter int NUM_EXPERTS = eslr_pkg::DEF_NUM_EXPERTS,
  parameter int SLOTS       = eslr_pkg::DEF_SLOTS,
  parameter int MAX_BATCH   = eslr_pkg::DEF_MAX_BATCH,
  parameter int NUM_TABLES  = eslr_pkg::DEF_NUM_TABLES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  eslr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output eslr_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [eslr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eslr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import eslr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  eslr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  eslr_dpath #(
    .NUM_EXPERTS (NUM_EXPERTS),
    .SLOTS       (SLOTS),
    .MAX_BATCH   (MAX_BATCH),
    .NUM_TABLES  (NUM_TABLES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- design/eslr_ctrl.sv -----
// Controller: sequences clearing, item handling and reservation passes.
module eslr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  eslr_pkg::in_item_t in_data,
  input  eslr_pkg::stat_t  stat,
  output logic             busy,
  output eslr_pkg::cmd_t   cmd
);
  import eslr_pkg::*;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_RET      = 5'd2;
  localparam logic [4:0] S_PUB_RD   = 5'd3;
  localparam logic [4:0] S_PUB_WR   = 5'd4;
  localparam logic [4:0] S_INIT     = 5'd5;
  localparam logic [4:0] S_LEG_RD   = 5'd6;
  localparam logic [4:0] S_LEG_EV   = 5'd7;
  localparam logic [4:0] S_BUMP_RD  = 5'd8;
  localparam logic [4:0] S_BUMP_EV  = 5'd9;
  localparam logic [4:0] S_MISS_RD  = 5'd10;
  localparam logic [4:0] S_MISS_EV  = 5'd11;
  localparam logic [4:0] S_POP      = 5'd12;
  localparam logic [4:0] S_VIC_RD   = 5'd13;
  localparam logic [4:0] S_VIC_EV   = 5'd14;
  localparam logic [4:0] S_VIC_END  = 5'd15;
  localparam logic [4:0] S_FLUSH    = 5'd16;

  logic [4:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Decide next state and issue the datapath operation
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_ACCEPT;
          case (in_data.action)
            ACT_PREDICT: if (in_data.batch_last) state_nxt = S_INIT;
            ACT_PUBLISH: state_nxt = S_PUB_RD;
            ACT_RETURN:  state_nxt = S_RET;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RET: begin
        cmd.op    = OP_RET;
        state_nxt = S_IDLE;
      end
      S_PUB_RD: begin
        cmd.op    = OP_PUB_RD;
        state_nxt = S_PUB_WR;
      end
      S_PUB_WR: begin
        cmd.op    = OP_PUB_WR;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        cmd.op = OP_INIT;
        if (stat.init_done) state_nxt = stat.lfu ? S_BUMP_RD : S_LEG_RD;
      end
      S_LEG_RD: begin
        cmd.op    = OP_LEG_RD;
        state_nxt = S_LEG_EV;
      end
      S_LEG_EV: begin
        cmd.op    = OP_LEG_EV;
        state_nxt = stat.scan_last ? S_MISS_RD : S_LEG_RD;
      end
      S_BUMP_RD: begin
        cmd.op    = OP_BUMP_RD;
        state_nxt = stat.bump_done ? S_MISS_RD : S_BUMP_EV;
      end
      S_BUMP_EV: begin
        cmd.op    = OP_BUMP_EV;
        state_nxt = S_BUMP_RD;
      end
      S_MISS_RD: begin
        cmd.op    = OP_MISS_RD;
        state_nxt = stat.miss_done ? S_FLUSH : S_MISS_EV;
      end
      S_MISS_EV: begin
        cmd.op = OP_MISS_EV;
        if (stat.hit)           state_nxt = S_MISS_RD;
        else if (stat.depth_nz) state_nxt = S_POP;
        else if (stat.lfu)      state_nxt = S_VIC_RD;
        else                    state_nxt = S_MISS_RD;
      end
      S_POP: begin
        cmd.op    = OP_POP;
        state_nxt = S_MISS_RD;
      end
      S_VIC_RD: begin
        cmd.op    = OP_VIC_RD;
        state_nxt = S_VIC_EV;
      end
      S_VIC_EV: begin
        cmd.op    = OP_VIC_EV;
        state_nxt = stat.scan_last ? S_VIC_END : S_VIC_RD;
      end
      S_VIC_END: begin
        cmd.op    = OP_VIC_END;
        state_nxt = S_MISS_RD;
      end
      S_FLUSH: begin
        cmd.op    = OP_FLUSH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ----- design/eslr_dpath.sv -----
// Datapath: configuration, map/count memory, free stacks, batch set and results.
module eslr_dpath #(
  parameter int NUM_EXPERTS = eslr_pkg::DEF_NUM_EXPERTS,
  parameter int SLOTS       = eslr_pkg::DEF_SLOTS,
  parameter int MAX_BATCH   = eslr_pkg::DEF_MAX_BATCH,
  parameter int NUM_TABLES  = eslr_pkg::DEF_NUM_TABLES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  eslr_pkg::in_item_t               in_data,
  input  eslr_pkg::cmd_t                   cmd,
  output eslr_pkg::stat_t                  stat,
  input  logic                             cfg_valid,
  input  logic [eslr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eslr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  output eslr_pkg::out_item_t              out_data
);
  import eslr_pkg::*;

  localparam int EW        = $clog2(NUM_EXPERTS);
  localparam int TW        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int MAP_DEPTH = NUM_TABLES * NUM_EXPERTS;
  localparam int MAW       = $clog2(MAP_DEPTH);
  localparam int STK_DEPTH = NUM_TABLES * SLOTS;
  localparam int SAW       = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
  localparam int DW        = $clog2(SLOTS + 1);
  localparam int BW        = $clog2(MAX_BATCH + 1);
  localparam int BIW       = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int NW        = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             present;
    logic [CNT_W-1:0] cnt;
  } map_word_t;

  // Configuration
  logic                  lfu_mode_r, lfu_mode_nxt;
  logic [63:0]           resident_mask_r, resident_mask_nxt;
  logic [4:0]            spec_slots_r, spec_slots_nxt;
  logic [ROW_W-1:0]      base_row_r, base_row_nxt;

  // Per-table state
  logic [NUM_TABLES-1:0] table_ready_r, table_ready_nxt;
  logic [DW-1:0]         free_depth_r [NUM_TABLES];
  logic [DW-1:0]         free_depth_nxt [NUM_TABLES];

  // Batch set
  logic [EW-1:0]          batch_list_r [MAX_BATCH];
  logic [EW-1:0]          batch_list_nxt [MAX_BATCH];
  logic [BW-1:0]          batch_len_r, batch_len_nxt;
  logic [NUM_EXPERTS-1:0] batch_member_r, batch_member_nxt;

  // Request and loop counters
  in_item_t         req_r, req_nxt;
  logic [TW-1:0]    tbl_r, tbl_nxt;
  logic [MAW-1:0]   clr_r, clr_nxt;
  logic [DW-1:0]    init_r, init_nxt;
  logic [EW-1:0]    scan_r, scan_nxt;
  logic [BW-1:0]    item_r, item_nxt;
  logic [NW-1:0]    n_r, n_nxt;

  // Victim search
  logic             best_valid_r, best_valid_nxt;
  logic [CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [EW-1:0]    best_e_r, best_e_nxt;
  logic [ROW_W-1:0] best_row_r, best_row_nxt;

  // Pending and output result
  logic             pend_valid_r, pend_valid_nxt;
  logic [EW-1:0]    pend_e_r, pend_e_nxt;
  logic [ROW_W-1:0] pend_row_r, pend_row_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // Memories
  map_word_t        map_mem [MAP_DEPTH];
  map_word_t        map_rd_r;
  logic             map_we, map_re;
  logic [MAW-1:0]   map_waddr, map_raddr;
  map_word_t        map_wdata;
  logic [ROW_W-1:0] stk_mem [STK_DEPTH];
  logic [ROW_W-1:0] stk_rd_r;
  logic             stk_we, stk_re;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [ROW_W-1:0] stk_wdata;

  // Helpers
  logic [TW-1:0]    tbl_lut [8];
  logic [TW-1:0]    in_tbl;
  logic [DW-1:0]    dep;
  logic [6:0]       spec_k;
  logic             in_ok, req_ok, add_ok, cand;
  logic [EW-1:0]    cur_e;
  logic [CNT_W-1:0] rd_cnt, bump_cnt;
  logic             push_en;
  logic [ROW_W-1:0] push_row;
  logic             emit_new;
  logic [ROW_W-1:0] new_row;

  // Wrap table index
  always_comb begin
    for (int i = 0; i < 8; i++) tbl_lut[i] = TW'(i % NUM_TABLES);
  end
  assign in_tbl = tbl_lut[in_data.table_index];

  assign dep    = free_depth_r[tbl_r];
  assign spec_k = (7'(spec_slots_r) > 7'(SLOTS)) ? 7'(SLOTS) : 7'(spec_slots_r);
  assign in_ok  = 7'(in_data.expert_id) < 7'(NUM_EXPERTS);
  assign req_ok = 7'(req_r.expert_id) < 7'(NUM_EXPERTS);
  assign add_ok = in_ok && !resident_mask_r[in_data.expert_id]
                  && !batch_member_r[EW'(in_data.expert_id)]
                  && (batch_len_r < BW'(MAX_BATCH));
  assign cur_e  = batch_list_r[item_r[BIW-1:0]];
  assign rd_cnt = map_rd_r.present ? map_rd_r.cnt : '0;
  assign bump_cnt = (rd_cnt != {CNT_W{1'b1}}) ? rd_cnt + 1'b1 : rd_cnt;
  assign cand   = map_rd_r.valid && !batch_member_r[scan_r];

  // Status to the controller
  always_comb begin
    stat.clr_done  = (clr_r == MAW'(MAP_DEPTH - 1));
    stat.init_done = table_ready_r[tbl_r] || (7'(init_r) >= spec_k);
    stat.lfu       = lfu_mode_r;
    stat.scan_last = (scan_r == EW'(NUM_EXPERTS - 1));
    stat.bump_done = (item_r >= batch_len_r);
    stat.miss_done = (item_r >= batch_len_r) || (n_r >= NW'(MAX_RESULTS));
    stat.hit       = map_rd_r.valid;
    stat.depth_nz  = (dep != '0);
  end

  // Next-state logic for all operations
  always_comb begin
    lfu_mode_nxt      = lfu_mode_r;
    resident_mask_nxt = resident_mask_r;
    spec_slots_nxt    = spec_slots_r;
    base_row_nxt      = base_row_r;
    table_ready_nxt   = table_ready_r;
    free_depth_nxt    = free_depth_r;
    batch_list_nxt    = batch_list_r;
    batch_len_nxt     = batch_len_r;
    batch_member_nxt  = batch_member_r;
    req_nxt           = req_r;
    tbl_nxt           = tbl_r;
    clr_nxt           = clr_r;
    init_nxt          = init_r;
    scan_nxt          = scan_r;
    item_nxt          = item_r;
    n_nxt             = n_r;
    best_valid_nxt    = best_valid_r;
    best_cnt_nxt      = best_cnt_r;
    best_e_nxt        = best_e_r;
    best_row_nxt      = best_row_r;
    pend_valid_nxt    = pend_valid_r;
    pend_e_nxt        = pend_e_r;
    pend_row_nxt      = pend_row_r;
    out_valid_nxt     = 1'b0;
    out_data_nxt      = out_data_r;
    map_we            = 1'b0;
    map_re            = 1'b0;
    map_waddr         = '0;
    map_raddr         = '0;
    map_wdata         = '0;
    stk_re            = 1'b0;
    stk_we            = 1'b0;
    stk_raddr         = '0;
    stk_waddr         = '0;
    stk_wdata         = '0;
    push_en           = 1'b0;
    push_row          = '0;
    emit_new          = 1'b0;
    new_row           = '0;

    // Take configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LFU_MODE:      lfu_mode_nxt      = cfg_data[0];
        CFG_RESIDENT_MASK: resident_mask_nxt = cfg_data;
        CFG_SPEC_SLOTS:    spec_slots_nxt    = cfg_data[4:0];
        CFG_BASE_ROW:      base_row_nxt      = cfg_data[ROW_W-1:0];
        default:           lfu_mode_nxt      = lfu_mode_r;
      endcase
    end

    case (cmd.op)
      OP_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      OP_ACCEPT: begin
        req_nxt = in_data;
        tbl_nxt = in_tbl;
        if (in_data.action == ACT_PREDICT && add_ok) begin
          batch_list_nxt[batch_len_r[BIW-1:0]]    = EW'(in_data.expert_id);
          batch_len_nxt                           = batch_len_r + 1'b1;
          batch_member_nxt[EW'(in_data.expert_id)] = 1'b1;
        end
      end
      OP_RET: begin
        push_en  = 1'b1;
        push_row = req_r.row;
      end
      OP_PUB_RD: begin
        map_re    = 1'b1;
        map_raddr = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(EW'(req_r.expert_id));
      end
      OP_PUB_WR: begin
        // Map the expert; seed its count when absent
        if (req_ok) begin
          map_we          = 1'b1;
          map_waddr       = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(EW'(req_r.expert_id));
          map_wdata.valid = 1'b1;
          map_wdata.row   = req_r.row;
          if (map_rd_r.present) begin
            map_wdata.present = 1'b1;
            map_wdata.cnt     = map_rd_r.cnt;
          end else begin
            map_wdata.present = 1'b1;
            map_wdata.cnt     = CNT_W'(1);
          end
        end
      end
      OP_INIT: begin
        if (stat.init_done) begin
          table_ready_nxt[tbl_r] = 1'b1;
          init_nxt               = '0;
          scan_nxt               = '0;
          item_nxt               = '0;
          n_nxt                  = '0;
        end else begin
          push_en  = 1'b1;
          push_row = base_row_r + ROW_W'(init_r);
          init_nxt = init_r + 1'b1;
        end
      end
      OP_LEG_RD: begin
        map_re    = 1'b1;
        map_raddr = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(scan_r);
      end
      OP_LEG_EV: begin
        // Drop a mapped expert outside the set, keep its count
        if (cand) begin
          push_en           = 1'b1;
          push_row          = map_rd_r.row;
          map_we            = 1'b1;
          map_waddr         = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(scan_r);
          map_wdata.present = map_rd_r.present;
          map_wdata.cnt     = map_rd_r.cnt;
        end
        scan_nxt = scan_r + 1'b1;
      end
      OP_BUMP_RD: begin
        if (stat.bump_done) begin
          item_nxt = '0;
        end else begin
          map_re    = 1'b1;
          map_raddr = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(cur_e);
        end
      end
      OP_BUMP_EV: begin
        if (map_rd_r.valid) begin
          map_we            = 1'b1;
          map_waddr         = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(cur_e);
          map_wdata         = map_rd_r;
          map_wdata.present = 1'b1;
          map_wdata.cnt     = bump_cnt;
        end
        item_nxt = item_r + 1'b1;
      end
      OP_MISS_RD: begin
        if (!stat.miss_done) begin
          map_re    = 1'b1;
          map_raddr = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(cur_e);
        end
      end
      OP_MISS_EV: begin
        if (map_rd_r.valid) begin
          item_nxt = item_r + 1'b1;
        end else if (dep != '0) begin
          stk_re                = 1'b1;
          stk_raddr             = SAW'(tbl_r) * SAW'(SLOTS) + SAW'(dep - 1'b1);
          free_depth_nxt[tbl_r] = dep - 1'b1;
        end else if (lfu_mode_r) begin
          scan_nxt       = '0;
          best_valid_nxt = 1'b0;
        end else begin
          item_nxt = item_r + 1'b1;
        end
      end
      OP_POP: begin
        emit_new = 1'b1;
        new_row  = stk_rd_r;
        item_nxt = item_r + 1'b1;
      end
      OP_VIC_RD: begin
        map_re    = 1'b1;
        map_raddr = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(scan_r);
      end
      OP_VIC_EV: begin
        // Keep the least count; ascending scan keeps the smallest id on ties
        if (cand && (!best_valid_r || rd_cnt < best_cnt_r)) begin
          best_valid_nxt = 1'b1;
          best_cnt_nxt   = rd_cnt;
          best_e_nxt     = scan_r;
          best_row_nxt   = map_rd_r.row;
        end
        scan_nxt = scan_r + 1'b1;
      end
      OP_VIC_END: begin
        if (best_valid_r) begin
          map_we    = 1'b1;
          map_waddr = MAW'(tbl_r) * MAW'(NUM_EXPERTS) + MAW'(best_e_r);
          emit_new  = 1'b1;
          new_row   = best_row_r;
        end
        item_nxt = item_r + 1'b1;
      end
      OP_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_valid_r) begin
          out_data_nxt.reserved_expert = EXP_W'(pend_e_r);
          out_data_nxt.reserved_row    = pend_row_r;
          out_data_nxt.nothing_to_read = 1'b0;
        end else begin
          out_data_nxt.reserved_expert = '0;
          out_data_nxt.reserved_row    = '0;
          out_data_nxt.nothing_to_read = 1'b1;
        end
        out_data_nxt.run_last = 1'b1;
        pend_valid_nxt        = 1'b0;
        batch_len_nxt         = '0;
        batch_member_nxt      = '0;
        n_nxt                 = '0;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase

    // Push onto the table's free stack unless full
    if (push_en && dep < DW'(SLOTS)) begin
      stk_we                = 1'b1;
      stk_waddr             = SAW'(tbl_r) * SAW'(SLOTS) + SAW'(dep);
      stk_wdata             = push_row;
      free_depth_nxt[tbl_r] = dep + 1'b1;
    end

    // Release the held result and hold the new one
    if (emit_new) begin
      if (pend_valid_r) begin
        out_valid_nxt                = 1'b1;
        out_data_nxt.reserved_expert = EXP_W'(pend_e_r);
        out_data_nxt.reserved_row    = pend_row_r;
        out_data_nxt.nothing_to_read = 1'b0;
        out_data_nxt.run_last        = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_e_nxt     = cur_e;
      pend_row_nxt   = new_row;
      n_nxt          = n_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfu_mode_r      <= 1'b1;
      resident_mask_r <= '0;
      spec_slots_r    <= 5'd16;
      base_row_r      <= '0;
      table_ready_r   <= '0;
      for (int i = 0; i < NUM_TABLES; i++) free_depth_r[i] <= '0;
      batch_len_r     <= '0;
      batch_member_r  <= '0;
      tbl_r           <= '0;
      clr_r           <= '0;
      init_r          <= '0;
      n_r             <= '0;
      pend_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      lfu_mode_r      <= lfu_mode_nxt;
      resident_mask_r <= resident_mask_nxt;
      spec_slots_r    <= spec_slots_nxt;
      base_row_r      <= base_row_nxt;
      table_ready_r   <= table_ready_nxt;
      free_depth_r    <= free_depth_nxt;
      batch_len_r     <= batch_len_nxt;
      batch_member_r  <= batch_member_nxt;
      tbl_r           <= tbl_nxt;
      clr_r           <= clr_nxt;
      init_r          <= init_nxt;
      n_r             <= n_nxt;
      pend_valid_r    <= pend_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    batch_list_r <= batch_list_nxt;
    req_r        <= req_nxt;
    scan_r       <= scan_nxt;
    item_r       <= item_nxt;
    best_valid_r <= best_valid_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_e_r     <= best_e_nxt;
    best_row_r   <= best_row_nxt;
    pend_e_r     <= pend_e_nxt;
    pend_row_r   <= pend_row_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Map and count memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd_r <= map_mem[map_raddr];
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_r <= stk_mem[stk_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.nothing_to_read |-> out_data.run_last)
    else $error("empty reservation not marked last");

  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_RESULTS))
    else $error("result count over limit");

  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    free_depth_r[tbl_r] <= DW'(SLOTS))
    else $error("free stack overfilled");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FLUSH |=> batch_len_r == '0 && !pend_valid_r)
    else $error("batch not cleared after flush");

endmodule
